@@ hdl/dvs_pkg.sv @@
// shared types and constants for the 64-bit signed/unsigned divider
// depends on nothing; imported by every module of the block
package dvs_pkg;

   // width of every operand and result field on the ports
   localparam int FIELD_W = 64;

   // entries in the queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // opcode values carried in req_tuser
   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   // sign fixups decided by the front and applied after the last step
   typedef struct packed {
      logic quo_neg;
      logic rem_neg;
   } dvs_sign_type;

endpackage

@@ hdl/dvs_front.sv @@
// front end: takes a transaction and turns signed operands into magnitudes
// depends on dvs_pkg
module dvs_front
   import dvs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             opcode,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] dividend_mag,
   output logic [WIDTH-1:0] divisor_mag,
   output dvs_sign_type     sign
);

   logic n_neg;
   logic d_neg;

   always_comb begin
      n_neg = (opcode == OP_SIGNED) && dividend[WIDTH-1];
      d_neg = (opcode == OP_SIGNED) && divisor[WIDTH-1];
      dividend_mag = n_neg ? (~dividend + WIDTH'(1)) : dividend;
      divisor_mag  = d_neg ? (~divisor + WIDTH'(1)) : divisor;
      sign.quo_neg = n_neg ^ d_neg;
      // remainder follows the dividend's sign
      sign.rem_neg = n_neg;
   end

endmodule

@@ hdl/dvs_queue.sv @@
// short register queue between the front and the back
// depends on dvs_pkg for the queue depth
module dvs_queue
   import dvs_pkg::*;
#(
   parameter int DATA_W = 130
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  logic [DATA_W-1:0] wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output logic [DATA_W-1:0] rd_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   always_comb begin
      wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
      rd_valid = (count_ff != '0);
      rd_data  = mem_ff[rd_ptr_ff];
      do_wr    = wr_valid && wr_ready;
      do_rd    = rd_valid && rd_ready;

      wr_ptr_in = wr_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hdl/dvs_back.sv @@
// back end: one restoring shift-subtract step per stage, then sign fixup
// depends on dvs_pkg
module dvs_back
   import dvs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [WIDTH-1:0]   in_dividend,
   input  logic [WIDTH-1:0]   in_divisor,
   input  dvs_sign_type       in_sign,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [FIELD_W-1:0] out_quotient,
   output logic [FIELD_W-1:0] out_remainder
);

   // per stage: partial remainder, dividend bits still to shift in merged
   // with quotient bits already formed, divisor and sign fixups
   logic [WIDTH-1:0] rem_ff [WIDTH];
   logic [WIDTH-1:0] rem_in [WIDTH];
   logic [WIDTH-1:0] nq_ff  [WIDTH];
   logic [WIDTH-1:0] nq_in  [WIDTH];
   logic [WIDTH-1:0] den_ff [WIDTH];
   logic [WIDTH-1:0] den_in [WIDTH];
   dvs_sign_type     sign_ff [WIDTH];
   dvs_sign_type     sign_in [WIDTH];
   logic [WIDTH-1:0] vld_ff, vld_in;

   logic             out_vld_ff, out_vld_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rmd_ff, rmd_in;
   logic             advance;

   logic [WIDTH-1:0] src_rem [WIDTH];
   logic [WIDTH-1:0] src_nq  [WIDTH];
   logic [WIDTH:0]   shifted [WIDTH];
   logic [WIDTH:0]   diff    [WIDTH];
   logic             fits    [WIDTH];

   // whole pipe moves together whenever the output register can take a result
   assign advance  = !out_vld_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      vld_in = {vld_ff[WIDTH-2:0], in_valid};
      for (int k = 0; k < WIDTH; k++) begin
         if (k == 0) begin
            src_rem[k] = '0;
            src_nq[k]  = in_dividend;
            den_in[k]  = in_divisor;
            sign_in[k] = in_sign;
         end else begin
            src_rem[k] = rem_ff[k-1];
            src_nq[k]  = nq_ff[k-1];
            den_in[k]  = den_ff[k-1];
            sign_in[k] = sign_ff[k-1];
         end
         shifted[k] = {src_rem[k], src_nq[k][WIDTH-1]};
         diff[k]    = shifted[k] - {1'b0, den_in[k]};
         fits[k]    = (shifted[k] >= {1'b0, den_in[k]});
         rem_in[k]  = fits[k] ? diff[k][WIDTH-1:0] : shifted[k][WIDTH-1:0];
         nq_in[k]   = {src_nq[k][WIDTH-2:0], fits[k]};
      end

      out_vld_in = vld_ff[WIDTH-1];
      quo_in = sign_ff[WIDTH-1].quo_neg ? (~nq_ff[WIDTH-1] + WIDTH'(1)) : nq_ff[WIDTH-1];
      rmd_in = sign_ff[WIDTH-1].rem_neg ? (~rem_ff[WIDTH-1] + WIDTH'(1)) : rem_ff[WIDTH-1];

      out_valid     = out_vld_ff;
      out_quotient  = '0;
      out_remainder = '0;
      out_quotient[WIDTH-1:0]  = quo_ff;
      out_remainder[WIDTH-1:0] = rmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < WIDTH; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            den_ff[k]  <= den_in[k];
            sign_ff[k] <= sign_in[k];
         end
         quo_ff <= quo_in;
         rmd_ff <= rmd_in;
      end
   end

endmodule

@@ hdl/divider_64bit_signed_unsigned_top.sv @@
// top level of the 64-bit signed/unsigned restoring divider
// depends on dvs_pkg, dvs_front, dvs_queue and dvs_back
//
// Divides dividend by divisor, unsigned when req_tuser is 0 and two's
// complement signed when it is 1, returning quotient and remainder in one
// rsp transaction per req transaction, in order. Signed results truncate
// toward zero and the remainder carries the dividend's sign; the most
// negative value over minus one wraps to itself with remainder zero. Division
// by zero returns all ones (unsigned, or signed with a non-negative dividend)
// or one (signed, negative dividend) as quotient, and the dividend as
// remainder. Only the low WIDTH bits of each operand are used and result bits
// at WIDTH and above read zero. A new transaction is taken every cycle while
// the queue is not full: the front converts operands to magnitudes into a
// two-entry queue, and the back is a pipeline of WIDTH shift-subtract stages
// plus one sign fixup stage. While rsp is stalled the back holds and the queue
// keeps taking requests until full.
// There is no state to clear after reset.
module divider_64bit_signed_unsigned_top
   import dvs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*FIELD_W-1:0] req_tdata,   // dividend [63:0], divisor [127:64]
   input  logic                 req_tuser,   // opcode [0]
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*FIELD_W-1:0] rsp_tdata    // quotient [63:0], remainder [127:64]
);

   localparam int SIGN_W  = $bits(dvs_sign_type);
   localparam int QUEUE_W = SIGN_W + 2 * WIDTH;

   // operand magnitudes and sign fixups from the front
   logic [WIDTH-1:0]   fr_dividend;
   logic [WIDTH-1:0]   fr_divisor;
   dvs_sign_type       fr_sign;

   // queue output toward the back
   logic               qu_valid;
   logic               qu_ready;
   logic [QUEUE_W-1:0] qu_data;

   logic [FIELD_W-1:0] quotient;
   logic [FIELD_W-1:0] remainder;

   dvs_front #(
      .WIDTH (WIDTH)
   ) u_front (
      .opcode       (req_tuser),
      .dividend     (req_tdata[WIDTH-1:0]),
      .divisor      (req_tdata[FIELD_W+WIDTH-1:FIELD_W]),
      .dividend_mag (fr_dividend),
      .divisor_mag  (fr_divisor),
      .sign         (fr_sign)
   );

   // accepted request transactions wait here when the back is stalled
   dvs_queue #(
      .DATA_W (QUEUE_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  ({fr_sign, fr_divisor, fr_dividend}),
      .rd_valid (qu_valid),
      .rd_ready (qu_ready),
      .rd_data  (qu_data)
   );

   dvs_back #(
      .WIDTH (WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (qu_valid),
      .in_ready      (qu_ready),
      .in_dividend   (qu_data[WIDTH-1:0]),
      .in_divisor    (qu_data[2*WIDTH-1:WIDTH]),
      .in_sign       (dvs_sign_type'(qu_data[QUEUE_W-1:2*WIDTH])),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_quotient  (quotient),
      .out_remainder (remainder)
   );

   assign rsp_tdata = {remainder, quotient};

endmodule

@@ bench/division_board_pkg.sv @@
// result tracking for the divider bench: the expected quotient/remainder
// store and its checker; depends on dvs_pkg for the field width
package division_board_pkg;

   import dvs_pkg::*;

   typedef logic [FIELD_W-1:0] word_type;

   typedef struct packed {
      word_type quo;
      word_type rem;
   } division_type;

   class division_board;
      division_type awaited[$];
      int unsigned  checked;
      int unsigned  failures;

      function new();
         checked  = 0;
         failures = 0;
      endfunction

      // shift-subtract on magnitudes, one quotient bit per position
      function division_type restoring_divide(word_type num, word_type den);
         division_type     res;
         logic [FIELD_W:0] part;
         if (den == '0) begin
            res.quo = '1;
            res.rem = num;
            return res;
         end
         part    = '0;
         res.quo = '0;
         for (int b = FIELD_W - 1; b >= 0; b--) begin
            part = {part[FIELD_W-1:0], num[b]};
            if (part >= {1'b0, den}) begin
               part       = part - {1'b0, den};
               res.quo[b] = 1'b1;
            end
         end
         res.rem = part[FIELD_W-1:0];
         return res;
      endfunction

      function division_type predict_division(logic op, word_type num, word_type den);
         division_type res;
         logic         num_neg;
         logic         den_neg;
         if (op == OP_UNSIGNED) return restoring_divide(num, den);
         num_neg = num[FIELD_W-1];
         den_neg = den[FIELD_W-1];
         res = restoring_divide(num_neg ? ~num + 1'b1 : num,
                                den_neg ? ~den + 1'b1 : den);
         if (num_neg != den_neg) res.quo = ~res.quo + 1'b1;
         if (num_neg) res.rem = ~res.rem + 1'b1;
         return res;
      endfunction

      function void note_request(logic op, word_type num, word_type den);
         awaited.push_back(predict_division(op, num, den));
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      task report_mismatch(string what, word_type got, word_type want);
         failures++;
         $display("%0t: %s got %h, want %h", $time, what, got, want);
      endtask

      task check_result(logic [2*FIELD_W-1:0] data);
         division_type want;
         checked++;
         if (awaited.size() == 0) begin
            report_mismatch("result with nothing pending, quotient", data[FIELD_W-1:0], '0);
            return;
         end
         want = awaited.pop_front();
         if (data[FIELD_W-1:0] !== want.quo)
            report_mismatch("quotient", data[FIELD_W-1:0], want.quo);
         if (data[2*FIELD_W-1:FIELD_W] !== want.rem)
            report_mismatch("remainder", data[2*FIELD_W-1:FIELD_W], want.rem);
      endtask
   endclass

endpackage

@@ bench/divider_64bit_signed_unsigned_top_tb.sv @@
// self-checking bench for the 64-bit signed/unsigned divider top level
// depends on dvs_pkg, division_board_pkg and the divider RTL
module divider_64bit_signed_unsigned_top_tb;
   import dvs_pkg::*;
   import division_board_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400_000;   // far beyond the slowest legal run
   localparam int RANDOM_COUNT = 1726;      // plus the directed ones, about 1750
   localparam int DRAIN_CYCLES = FIELD_W + 16;

   localparam word_type ALL_ONES = '1;
   localparam word_type MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [2*FIELD_W-1:0] req_tdata = '0;   // dividend [63:0], divisor [127:64]
   logic                 req_tuser = OP_UNSIGNED;   // opcode [0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*FIELD_W-1:0] rsp_tdata;        // quotient [63:0], remainder [127:64]

   division_board board = new();

   int unsigned cycle_count = 0;
   int unsigned n_unsigned  = 0;
   int unsigned n_signed    = 0;
   int unsigned n_by_zero   = 0;

   // no idle gaps while a side is in a steady stretch
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   divider_64bit_signed_unsigned_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // per-transaction random wait, or none in a steady stretch
   function automatic int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   // random value limited to the given number of low bits
   function automatic word_type rand_bits(int nbits);
      return rand_word() >> (FIELD_W - nbits);
   endfunction

   function automatic word_type maybe_negate(word_type v);
      return $urandom_range(0, 1) ? ~v + 1'b1 : v;
   endfunction

   // corner operands: 0, 1, 2, -1, -2, the signed extremes and the most negative plus one
   function automatic word_type pick_corner();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return word_type'(1);
         2:       return word_type'(2);
         3:       return ALL_ONES;
         4:       return MOST_NEG;
         5:       return MOST_POS;
         6:       return MOST_NEG + 1'b1;
         default: return ALL_ONES - 1'b1;
      endcase
   endfunction

   // one request transaction; entered and left at a falling edge
   task automatic send_division(logic op, word_type num, word_type den);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {den, num};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, num, den);
      if (op == OP_SIGNED) n_signed++; else n_unsigned++;
      if (den == '0) n_by_zero++;
      if ($urandom_range(0, 39) == 0) req_steady = ~req_steady;
      @(negedge clock);
   endtask

   // response side: stall a random number of cycles before each transaction
   task automatic take_results();
      int gap;
      forever begin
         gap = draw_gap(rsp_steady);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata);
         if ($urandom_range(0, 39) == 0) rsp_steady = ~rsp_steady;
         @(negedge clock);
      end
   endtask

   // random operand pair, weighted toward shapes that exercise the quotient bits
   task automatic send_random_division();
      logic     op;
      word_type num;
      word_type den;
      op = $urandom_range(0, 1) ? OP_SIGNED : OP_UNSIGNED;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            num = rand_word();
            den = rand_word();
         end
         3: begin   // small divisor, long quotient
            num = rand_word();
            den = maybe_negate(rand_bits($urandom_range(1, 16)));
         end
         4: begin   // dividend smaller than divisor
            den = rand_word();
            num = den >> $urandom_range(1, FIELD_W - 1);
         end
         5: begin   // small magnitudes of either sign
            num = maybe_negate(rand_bits($urandom_range(1, 16)));
            den = maybe_negate(rand_bits($urandom_range(1, 16)));
         end
         6: begin
            num = pick_corner();
            den = pick_corner();
         end
         7: begin   // division by zero
            num = $urandom_range(0, 1) ? rand_word() : pick_corner();
            den = '0;
         end
         8: begin   // exact multiples, remainder zero
            den = rand_bits($urandom_range(1, 32));
            num = maybe_negate(den * rand_bits($urandom_range(1, 32)));
            den = maybe_negate(den);
         end
         default: begin   // mixed operand lengths
            num = maybe_negate(rand_bits($urandom_range(1, FIELD_W)));
            den = maybe_negate(rand_bits($urandom_range(1, FIELD_W)));
         end
      endcase
      send_division(op, num, den);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         take_results();
      join_none

      // directed: unsigned extremes and division by zero
      send_division(OP_UNSIGNED, '0, word_type'(1));
      send_division(OP_UNSIGNED, ALL_ONES, word_type'(1));
      send_division(OP_UNSIGNED, ALL_ONES, ALL_ONES);
      send_division(OP_UNSIGNED, ALL_ONES, '0);
      send_division(OP_UNSIGNED, '0, '0);
      send_division(OP_UNSIGNED, word_type'(100), word_type'(7));
      send_division(OP_UNSIGNED, word_type'(7), word_type'(100));
      send_division(OP_UNSIGNED, MOST_NEG, word_type'(3));
      send_division(OP_UNSIGNED, ALL_ONES, MOST_NEG);
      // directed: signed overflow, signed division by zero, sign combinations
      send_division(OP_SIGNED, MOST_NEG, ALL_ONES);
      send_division(OP_SIGNED, MOST_NEG, word_type'(1));
      send_division(OP_SIGNED, MOST_NEG, '0);
      send_division(OP_SIGNED, -word_type'(5), '0);
      send_division(OP_SIGNED, word_type'(5), '0);
      send_division(OP_SIGNED, '0, '0);
      send_division(OP_SIGNED, -word_type'(7), word_type'(2));
      send_division(OP_SIGNED, word_type'(7), -word_type'(2));
      send_division(OP_SIGNED, -word_type'(7), -word_type'(2));
      send_division(OP_SIGNED, MOST_POS, ALL_ONES);
      send_division(OP_SIGNED, MOST_NEG, MOST_NEG);
      send_division(OP_SIGNED, ALL_ONES, MOST_NEG);
      send_division(OP_SIGNED, MOST_NEG, MOST_POS);
      send_division(OP_SIGNED, ALL_ONES, ALL_ONES);
      send_division(OP_SIGNED, MOST_POS, word_type'(2));

      repeat (RANDOM_COUNT) send_random_division();
      req_tvalid = 1'b0;

      // wait out every pending result, then watch for strays
      while (board.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d divisions (%0d unsigned, %0d signed, %0d by zero), %0d results checked",
               n_unsigned + n_signed, n_unsigned, n_signed, n_by_zero, board.checked);
      $display("random idle and stall gaps of 0 to 16 cycles on both channels");
      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
